// ----- design/semi_pkg.sv -----
package semi_pkg;

    // operand width and stream widths
    localparam int VALUE_BITS = 16;
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int S_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = 8;

    // request to the shared divider
    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [VALUE_BITS-1:0] divisor;
    } div_req_t;

    // answer from the shared divider
    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quot;
        logic [VALUE_BITS-1:0] rem;
    } div_rsp_t;

endpackage

// ----- design/semi_div.sv -----
module semi_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  semi_pkg::div_req_t req,
    output semi_pkg::div_rsp_t rsp
);

    logic [semi_pkg::VALUE_BITS-1:0] rem_reg, rem_next;
    logic [semi_pkg::VALUE_BITS-1:0] quo_reg, quo_next;
    logic [semi_pkg::VALUE_BITS-1:0] dvs_reg, dvs_next;
    logic [semi_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [semi_pkg::VALUE_BITS:0]   partial;
    logic                            fits;

    // one restoring step: bring down the next dividend bit
    assign partial = {rem_reg, quo_reg[semi_pkg::VALUE_BITS-1]};
    assign fits    = (partial >= {1'b0, dvs_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = semi_pkg::VALUE_BITS'(partial - {1'b0, dvs_reg});
            end else begin
                rem_next = partial[semi_pkg::VALUE_BITS-1:0];
            end
            quo_next = {quo_reg[semi_pkg::VALUE_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == semi_pkg::CNT_BITS'(semi_pkg::VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- design/semiprime_test_core.sv -----
// channel | direction | tdata fields (low bit up)        | handshake
// s_      | in        | value [VALUE_BITS-1:0]           | s_tvalid / s_tready
// m_      | out       | is_semiprime [0], rest zero      | m_tvalid / m_tready
//
// one item at a time; s_tready is high only while the sequencer is idle
// each candidate divisor costs one pass of the shared restoring divider
// plus the compare and step
// an item takes up to roughly 2^(VALUE_BITS/2) divider passes
// aresetn is synchronous and clears the sequencer and the result valid
// a finished result waits in the output register; a stalled m_ side holds the next result back
module semiprime_test_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [semi_pkg::S_DATA_W-1:0] s_tdata,  // value
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [semi_pkg::M_DATA_W-1:0] m_tdata   // is_semiprime, zero fill
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // which question the divisor loop is answering
    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_PRIME_D = 3'b010,
        PH_PRIME_Q = 3'b100
    } phase_t;

    localparam int N = semi_pkg::VALUE_BITS;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [N-1:0]      x_reg, x_next;
    logic [N-1:0]      q_reg, q_next;
    logic [N-1:0]      k_reg, k_next;
    logic [N:0]        sq_reg, sq_next;
    logic              res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_res_reg, m_res_next;
    semi_pkg::div_req_t div_req;
    semi_pkg::div_rsp_t div_rsp;

    semi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        x_next       = x_reg;
        q_next       = q_reg;
        k_next       = k_reg;
        sq_next      = sq_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_res_next   = m_res_reg;
        div_req.start    = 1'b0;
        div_req.dividend = x_reg;
        div_req.divisor  = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next     = s_tdata[N-1:0];
                    k_next     = N'(2);
                    sq_next    = (N+1)'(4);
                    phase_next = PH_SEARCH;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sq_reg > {1'b0, x_reg}) begin
                    // no divisor below the square root
                    case (phase_reg)
                        PH_SEARCH: begin
                            res_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                        PH_PRIME_D: begin
                            x_next     = q_reg;
                            k_next     = N'(2);
                            sq_next    = (N+1)'(4);
                            phase_next = PH_PRIME_Q;
                        end
                        default: begin
                            res_next   = 1'b1;
                            state_next = ST_DONE;
                        end
                    endcase
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.rem == '0) begin
                        if (phase_reg == PH_SEARCH) begin
                            // smallest factor found: test it, then the cofactor
                            q_next     = div_rsp.quot;
                            x_next     = k_reg;
                            k_next     = N'(2);
                            sq_next    = (N+1)'(4);
                            phase_next = PH_PRIME_D;
                            state_next = ST_CHECK;
                        end else begin
                            res_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                    end else begin
                        // (k+1)^2 = k^2 + 2k + 1
                        sq_next    = sq_reg + {k_reg, 1'b1};
                        k_next     = k_reg + 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_SEARCH;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // operands and result
    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        q_reg     <= q_next;
        k_reg     <= k_next;
        sq_reg    <= sq_next;
        res_reg   <= res_next;
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(semi_pkg::M_DATA_W-1){1'b0}}, m_res_reg};

    // divider is started only from the compare step
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> state_reg == ST_CHECK)
        else $error("divider started outside compare step");

    // divider answers arrive only while the sequencer waits for them
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider answer while not waiting");

    // the running square always matches the trial divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK || state_reg == ST_DIV)
        |-> sq_reg == ((N+1)'(k_reg) * (N+1)'(k_reg)))
        else $error("running square out of step with divisor");

    // an accepted item always starts at the compare step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == ST_CHECK)
        else $error("accepted item did not start the search");

endmodule

// ----- tb/sv/tb_semiprime_test_core.sv -----
`timescale 1ns / 100ps

module tb_semiprime_test_core;

    // run limit in clock cycles, well above the slowest legal run
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 50;
    localparam int unsigned LONG_HOLD    = 6000;
    localparam int unsigned RANDOM_ITEMS = 124;
    localparam longint unsigned VALUE_MASK = (64'd1 << semi_pkg::VALUE_BITS) - 1;
    localparam int unsigned HALF_MAX     = (1 << (semi_pkg::VALUE_BITS / 2)) - 1;

    typedef struct {
        longint unsigned value;
        bit              known;
        bit              verdict;
    } case_row_t;

    typedef struct {
        logic [semi_pkg::VALUE_BITS-1:0] value;
        bit                              verdict;
    } verdict_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [semi_pkg::S_DATA_W-1:0] s_tdata  = '0;  // value
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [semi_pkg::M_DATA_W-1:0] m_tdata;       // is_semiprime, zero fill

    verdict_t    pending_verdicts[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned cycle_count    = 0;
    bit          long_hold_done = 1'b0;

    // small values, primes, extremes and bit patterns
    case_row_t directed_rows [18] = '{
        '{0,     1'b1, 1'b0},
        '{1,     1'b1, 1'b0},
        '{2,     1'b1, 1'b0},
        '{3,     1'b1, 1'b0},
        '{5,     1'b1, 1'b0},
        '{65535, 1'b1, 1'b0},
        '{65521, 1'b1, 1'b0},
        '{4,     1'b0, 1'b0},
        '{6,     1'b0, 1'b0},
        '{8,     1'b0, 1'b0},
        '{9,     1'b0, 1'b0},
        '{49,    1'b0, 1'b0},
        '{64507, 1'b0, 1'b0},
        '{63001, 1'b0, 1'b0},
        '{32768, 1'b0, 1'b0},
        '{43690, 1'b0, 1'b0},
        '{21845, 1'b0, 1'b0},
        '{65534, 1'b0, 1'b0}
    };

    semiprime_test_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // trial division primality
    function automatic bit is_prime_trial(input longint unsigned x);
        longint unsigned k;
        if (x < 2) return 1'b0;
        for (k = 2; k * k <= x; k++) begin
            if (x % k == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // smallest factor d, then both d and x/d must be prime
    function automatic bit predict_semiprime(input longint unsigned value);
        longint unsigned x;
        longint unsigned d;
        x = value & VALUE_MASK;
        for (d = 2; d * d <= x; d++) begin
            if (x % d == 0) return is_prime_trial(d) && is_prime_trial(x / d);
        end
        return 1'b0;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // small values keep the divisor search short; a share of true semiprimes
    function automatic longint unsigned pick_value();
        int unsigned     r;
        longint unsigned p;
        longint unsigned q;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(0, 4095);
        if (r < 75) begin
            p = $urandom_range(2, HALF_MAX);
            while (!is_prime_trial(p)) p = $urandom_range(2, HALF_MAX);
            q = $urandom_range(2, HALF_MAX);
            while (!is_prime_trial(q)) q = $urandom_range(2, HALF_MAX);
            return p * q;
        end
        return $urandom_range(0, VALUE_MASK);
    endfunction

    task automatic note_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        $display("mismatch: %s got %0d want %0d", what, got, want);
        mismatch_count++;
    endtask

    // offer one item, record its verdict on acceptance, then drop s_tvalid for the gap when it is nonzero
    task automatic offer_value(input longint unsigned value, input bit known,
                               input bit verdict, input int unsigned gap);
        verdict_t entry;
        s_tvalid <= 1'b1;
        s_tdata  <= semi_pkg::S_DATA_W'(value & VALUE_MASK);
        do @(posedge aclk); while (!s_tready);
        entry.value   = semi_pkg::VALUE_BITS'(value);
        entry.verdict = known ? verdict : predict_semiprime(value);
        pending_verdicts.push_back(entry);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering until every pending verdict has come back
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_verdicts.size() != 0);
    endtask

    // reset, directed rows, random items, final drain
    initial begin
        int unsigned gap;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            offer_value(directed_rows[i].value, directed_rows[i].known,
                        directed_rows[i].verdict, pick_gap());
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 60) drain_verdicts();
            // a stretch with no sender gaps
            gap = (i >= 80 && i < 100) ? 0 : pick_gap();
            offer_value(pick_value(), 1'b0, 1'b0, gap);
        end
        drain_verdicts();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // receiver: random stalls, long ready runs, one long hold-off
    initial begin
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && results_seen >= 12) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_done = 1'b1;
            end else begin
                stall = pick_gap();
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_tready <= 1'b1;
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(100, 400)) @(posedge aclk);
                end else begin
                    repeat ($urandom_range(1, 30)) @(posedge aclk);
                end
            end
        end
    end

    // result check against the oldest pending verdict
    always @(posedge aclk) begin
        verdict_t entry;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                note_mismatch("result item with nothing pending, is_semiprime",
                              m_tdata[0], 0);
            end else begin
                entry = pending_verdicts.pop_front();
                if (m_tdata[0] !== entry.verdict) begin
                    note_mismatch($sformatf("is_semiprime for value %0d", entry.value),
                                  m_tdata[0], entry.verdict);
                end
                if (m_tdata[semi_pkg::M_DATA_W-1:1] !== '0) begin
                    note_mismatch($sformatf("tdata fill for value %0d", entry.value),
                                  m_tdata[semi_pkg::M_DATA_W-1:1], 0);
                end
            end
        end
    end

    // end the run if it hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// ----- semiprime_test_core.f -----
design/semi_pkg.sv
design/semi_div.sv
design/semiprime_test_core.sv
tb/sv/tb_semiprime_test_core.sv
